>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the rational arithmetic unit.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("%m: lbl");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error("%m: lbl");
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

>>> hw/rtl/rau_pkg.sv
// Package for the rational arithmetic unit: operation codes, command and
// status structs shared by controller and datapath. No dependencies.
package rau_pkg;
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_NEG = 3'd4;
  localparam logic [2:0] OP_CMP = 3'd5;
  localparam logic [2:0] OP_INT = 3'd6;
  localparam logic [2:0] OP_RED = 3'd7;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture operands, normalize
    logic mult;      // form cross products / numerator and denominator
    logic combine;   // signed add, pick result, set up gcd
    logic gcd_step;  // one binary gcd step
    logic div_start; // start dividing num and den by gcd
    logic div_step;  // one restoring division step on both
    logic finish;    // fit check, drive result register
  } rau_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic gcd_done;
    logic need_reduce;
    logic div_last;
  } rau_stat_t;
endpackage

>>> hw/rtl/rau_datapath.sv
// Datapath of the rational arithmetic unit: operand normalize, multiplies,
// binary gcd, bit-serial division. Depends on rau_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rau_datapath #(
  parameter int WORD_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rau_pkg::rau_cmd_t cmd_i,
  output rau_pkg::rau_stat_t stat_o,
  input  logic [2:0]        mode_i,
  input  logic [31:0]       a_num_i,
  input  logic [31:0]       a_den_i,
  input  logic [31:0]       b_num_i,
  input  logic [31:0]       b_den_i,
  output logic [31:0]       res_num_o,
  output logic [30:0]       res_den_o,
  output logic              less_o,
  output logic              equal_o,
  output logic              div_zero_o,
  output logic              overflow_o
);
  import rau_pkg::*;

  localparam logic [63:0] Limit = 64'd1 << (WORD_BITS - 1);
  localparam logic [63:0] WMask = (Limit << 1) - 64'd1;

  logic [2:0]  mode_q;
  logic        an_neg_q, bn_neg_q;
  logic [31:0] an_mag_q, ad_q, bn_mag_q, bd_q;
  logic        x_neg_q, y_neg_q;
  logic [63:0] x_q, y_q, den_q;
  logic        r_neg_q;
  logic [63:0] r_mag_q, rden_q;
  logic        dz_q, less_q, eq_q;
  // gcd state
  logic [63:0] gu_q, gv_q;
  logic [6:0]  gsh_q;
  logic [63:0] g_q;
  // division state
  logic [63:0] qn_q, qd_q, remn_q, remd_q;
  logic [6:0]  dcnt_q;

  function automatic logic [32:0] to_smag(input logic [31:0] v);
    logic [31:0] m;
    m = v[31] ? (32'd0 - v) : v;
    return {v[31], m};
  endfunction

  logic [32:0] an_s, ad_s, bn_s, bd_s;
  assign an_s = to_smag(a_num_i);
  assign ad_s = to_smag(a_den_i);
  assign bn_s = to_smag(b_num_i);
  assign bd_s = to_smag(b_den_i);

  // load: normalize operands
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q   <= mode_i;
      an_mag_q <= an_s[31:0];
      bn_mag_q <= bn_s[31:0];
      ad_q     <= (ad_s[31:0] == 32'd0) ? 32'd1 : ad_s[31:0];
      bd_q     <= (bd_s[31:0] == 32'd0) ? 32'd1 : bd_s[31:0];
      an_neg_q <= (an_s[32] ^ (ad_s[32] && ad_s[31:0] != 32'd0)) && an_s[31:0] != 32'd0;
      bn_neg_q <= (bn_s[32] ^ (bd_s[32] && bd_s[31:0] != 32'd0)) && bn_s[31:0] != 32'd0;
    end
  end

  // mult: one 32x32 per product, registered
  logic bsign;
  assign bsign = (mode_q == OP_SUB) ? !bn_neg_q : bn_neg_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.mult) begin
      unique case (mode_q)
        OP_MUL: begin
          x_q   <= 64'(an_mag_q) * 64'(bn_mag_q);
          x_neg_q <= an_neg_q ^ bn_neg_q;
          den_q <= 64'(ad_q) * 64'(bd_q);
          y_q <= '0; y_neg_q <= 1'b0;
        end
        OP_DIV: begin
          x_q   <= 64'(an_mag_q) * 64'(bd_q);
          x_neg_q <= an_neg_q ^ bn_neg_q;
          den_q <= 64'(ad_q) * 64'(bn_mag_q);
          y_q <= '0; y_neg_q <= 1'b0;
        end
        default: begin
          x_q   <= 64'(an_mag_q) * 64'(bd_q);
          x_neg_q <= an_neg_q;
          y_q   <= 64'(bn_mag_q) * 64'(ad_q);
          y_neg_q <= bsign;
          den_q <= 64'(ad_q) * 64'(bd_q);
        end
      endcase
    end
  end

  // combine
  logic        sum_neg;
  logic [63:0] sum_mag;
  always_comb begin
    if (x_neg_q == y_neg_q) begin
      sum_neg = x_neg_q; sum_mag = x_q + y_q;
    end else if (x_q >= y_q) begin
      sum_neg = x_neg_q; sum_mag = x_q - y_q;
    end else begin
      sum_neg = y_neg_q; sum_mag = y_q - x_q;
    end
  end

  logic        c_neg;
  logic [63:0] c_mag, c_den;
  logic        c_red, c_dz;
  always_comb begin
    c_neg = 1'b0; c_mag = '0; c_den = 64'd1; c_red = 1'b0; c_dz = 1'b0;
    unique case (mode_q)
      OP_ADD, OP_SUB: begin
        c_neg = sum_neg; c_mag = sum_mag; c_den = den_q; c_red = 1'b1;
      end
      OP_MUL: begin
        c_neg = x_neg_q; c_mag = x_q; c_den = den_q; c_red = 1'b1;
      end
      OP_DIV: begin
        if (bn_mag_q == 32'd0) begin
          c_neg = an_neg_q; c_mag = 64'(an_mag_q); c_den = 64'(ad_q); c_dz = 1'b1;
        end else begin
          c_neg = x_neg_q; c_mag = x_q; c_den = den_q; c_red = 1'b1;
        end
      end
      OP_NEG: begin
        c_neg = !an_neg_q; c_mag = 64'(an_mag_q); c_den = 64'(ad_q); c_red = 1'b1;
      end
      OP_CMP: ;
      OP_INT: begin
        // to_int: divide a_num by a_den, den 1
        c_neg = an_neg_q; c_mag = 64'(an_mag_q); c_den = 64'(ad_q); c_red = 1'b1;
      end
      default: begin
        c_neg = an_neg_q; c_mag = 64'(an_mag_q); c_den = 64'(ad_q); c_red = 1'b1;
      end
    endcase
    if (c_mag == 64'd0) begin
      c_neg = 1'b0;
      if (!c_dz) begin
        c_den = 64'd1; c_red = 1'b0;
      end
    end
  end

  logic cmp_lt, cmp_eq;
  always_comb begin
    cmp_eq = (x_neg_q == y_neg_q) && (x_q == y_q);
    if (x_neg_q != y_neg_q) cmp_lt = x_neg_q;
    else if (x_neg_q)        cmp_lt = x_q > y_q;
    else                     cmp_lt = x_q < y_q;
  end

  // one binary gcd step
  logic gdone;
  assign gdone = (gu_q == gv_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.combine) begin
      r_neg_q <= c_neg;
      r_mag_q <= c_mag;
      rden_q  <= c_den;
      dz_q    <= c_dz;
      less_q  <= (mode_q == OP_CMP) && cmp_lt;
      eq_q    <= (mode_q == OP_CMP) && cmp_eq;
      gu_q    <= c_mag;
      // to_int divides by den itself, no gcd needed
      gv_q    <= (mode_q == OP_INT) ? c_mag : c_den;
      gsh_q   <= '0;
      g_q     <= c_den;
    end else if (cmd_i.gcd_step && !gdone) begin
      if (!gu_q[0] && !gv_q[0]) begin
        gu_q <= gu_q >> 1; gv_q <= gv_q >> 1; gsh_q <= gsh_q + 7'd1;
      end else if (!gu_q[0]) begin
        gu_q <= gu_q >> 1;
      end else if (!gv_q[0]) begin
        gv_q <= gv_q >> 1;
      end else if (gu_q > gv_q) begin
        gu_q <= (gu_q - gv_q) >> 1;
      end else begin
        gv_q <= (gv_q - gu_q) >> 1;
      end
    end
    if (cmd_i.div_start) begin
      // divisor for to_int is the denominator, else the gcd
      qn_q   <= r_mag_q;
      qd_q   <= rden_q;
      remn_q <= '0;
      remd_q <= '0;
      dcnt_q <= '0;
      if (mode_q != OP_INT) g_q <= gu_q << gsh_q[5:0];
      else g_q <= rden_q;
    end else if (cmd_i.div_step) begin
      logic [64:0] tn, td;
      tn = {remn_q, qn_q[63]};
      td = {remd_q, qd_q[63]};
      if (tn >= {1'b0, g_q}) begin
        remn_q <= 64'(tn - {1'b0, g_q}); qn_q <= {qn_q[62:0], 1'b1};
      end else begin
        remn_q <= tn[63:0]; qn_q <= {qn_q[62:0], 1'b0};
      end
      if (td >= {1'b0, g_q}) begin
        remd_q <= 64'(td - {1'b0, g_q}); qd_q <= {qd_q[62:0], 1'b1};
      end else begin
        remd_q <= td[63:0]; qd_q <= {qd_q[62:0], 1'b0};
      end
      dcnt_q <= dcnt_q + 7'd1;
    end
  end

  assign stat_o.gcd_done    = gdone;
  assign stat_o.need_reduce = c_red;
  assign stat_o.div_last    = (dcnt_q == 7'd63);

  // finish: choose reduced or unreduced, fit check
  logic [63:0] f_mag, f_den, tc, low;
  logic        fits;
  logic        reduced_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) reduced_q <= 1'b0;
    else if (cmd_i.div_start) reduced_q <= 1'b1;
    else if (cmd_i.combine) reduced_q <= 1'b0;
  end
  always_comb begin
    f_mag = reduced_q ? qn_q : r_mag_q;
    f_den = reduced_q ? ((mode_q == OP_INT) ? 64'd1 : qd_q) : rden_q;
    fits  = (r_neg_q ? (f_mag <= Limit) : (f_mag < Limit)) && (f_den < Limit);
    tc    = r_neg_q ? (64'd0 - f_mag) : f_mag;
    low   = tc & WMask;
    if ((low & Limit) != 64'd0) low = low | ~WMask;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (mode_q == OP_CMP) begin
        res_num_o <= '0; res_den_o <= 31'd1; overflow_o <= 1'b0;
      end else begin
        res_num_o  <= low[31:0];
        res_den_o  <= 31'(f_den & (Limit - 64'd1));
        overflow_o <= !fits;
      end
      less_o     <= less_q;
      equal_o    <= eq_q;
      div_zero_o <= dz_q;
    end
  end

  `ASSERT_NEVER(cmp_flags_excl, clk_i, rst_ni, cmd_i.combine && cmp_lt && cmp_eq)
  `ASSERT_IMPL(gcd_nonzero, clk_i, rst_ni, cmd_i.div_start |-> gu_q != 64'd0)
  `ASSERT_IMPL(dz_no_reduce, clk_i, rst_ni, (cmd_i.combine && c_dz) |-> !c_red)
endmodule

>>> hw/rtl/rau_ctrl.sv
// Controller of the rational arithmetic unit: sequences load, multiply,
// gcd and division steps. Depends on rau_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rau_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rau_pkg::rau_cmd_t  cmd_o,
  input  rau_pkg::rau_stat_t stat_i
);
  import rau_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MULT = 3'd1;
  localparam logic [2:0] S_COMB = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       ov_q, ov_d;
  logic       red_q, red_d;

  logic busy;
  assign busy = (state_q != S_IDLE);
  // no new item while busy or while a stalled result waits
  assign in_stall_o = busy || (ov_q && out_stall_i);
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    ov_d    = ov_q && out_stall_i;
    red_d   = red_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: if (in_valid_i && !in_stall_o) begin
        cmd_o.load = 1'b1; state_d = S_MULT;
      end
      S_MULT: begin cmd_o.mult = 1'b1; state_d = S_COMB; end
      S_COMB: begin
        cmd_o.combine = 1'b1;
        red_d = stat_i.need_reduce;
        state_d = stat_i.need_reduce ? S_GCD : S_FIN;
      end
      S_GCD: begin
        cmd_o.gcd_step = 1'b1;
        if (stat_i.gcd_done) begin
          cmd_o.div_start = 1'b1; state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = S_FIN;
      end
      S_FIN: if (!(ov_q && out_stall_i)) begin
        cmd_o.finish = 1'b1; ov_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ov_q <= 1'b0; red_q <= 1'b0;
    end else begin
      state_q <= state_d; ov_q <= ov_d; red_q <= red_d;
    end
  end

  `ASSERT_IMPL(fin_not_clobber, clk_i, rst_ni, cmd_o.finish |-> !(ov_q && out_stall_i))
  `ASSERT_IMPL(load_only_idle, clk_i, rst_ni, cmd_o.load |-> state_q == S_IDLE)
  `ASSERT_IMPL(gcd_after_reduce, clk_i, rst_ni, (state_q == S_GCD) |-> red_q)
endmodule

>>> hw/rtl/rational_arithmetic_unit.sv
// Channel   Handshake              Payload
// in        in_valid_i/in_stall_o  mode_i a_num_i a_den_i b_num_i b_den_i
// out       out_valid_o/out_stall_i res_num_o res_den_o less_o equal_o div_zero_o overflow_o
// One item at a time: load, multiply, combine, then for reduced results a
// binary gcd and a 64-step bit-serial division of num and den by the gcd
// (by the denominator for to_int). Compare and unreduced results skip the
// gcd and the division. Reset clears control only.
// A stalled result holds; no new item is taken while it waits.
module rational_arithmetic_unit #(
  parameter int WORD_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [31:0] a_num_i,
  input  logic [31:0] a_den_i,
  input  logic [31:0] b_num_i,
  input  logic [31:0] b_den_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] res_num_o,
  output logic [30:0] res_den_o,
  output logic        less_o,
  output logic        equal_o,
  output logic        div_zero_o,
  output logic        overflow_o
);
  import rau_pkg::*;

  rau_cmd_t  cmd;
  rau_stat_t stat;

  rau_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o(cmd), .stat_i(stat)
  );

  rau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .mode_i, .a_num_i, .a_den_i, .b_num_i, .b_den_i,
    .res_num_o, .res_den_o, .less_o, .equal_o, .div_zero_o, .overflow_o
  );
endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for rational_arithmetic_unit: random and directed fraction
// operations with random idling on both channels. Depends on rau_pkg and the RTL.
module testbench;
  import rau_pkg::*;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] a_num, a_den, b_num, b_den;
    bit          drain;
  } op_item_t;

  typedef struct {
    logic [31:0] num;
    logic [30:0] den;
    logic        less, equal, div_zero, overflow;
  } frac_res_t;

  typedef struct {
    bit              neg;
    longint unsigned mag;
  } smag_t;

  typedef struct {
    smag_t           num;
    longint unsigned den;
  } frac_t;

  logic        clk_i = 0, rst_ni = 0;
  logic        in_valid_i = 0, out_stall_i = 0;
  logic        in_stall_o, out_valid_o;
  logic [2:0]  mode_i = OP_ADD;
  logic [31:0] a_num_i = 0, a_den_i = 0, b_num_i = 0, b_den_i = 0;
  logic [31:0] res_num_o;
  logic [30:0] res_den_o;
  logic        less_o, equal_o, div_zero_o, overflow_o;

  rational_arithmetic_unit dut (.*);

  op_item_t  pending_ops[$];
  frac_res_t expected_res[$];
  int        errors = 0;
  int        issued = 0, in_taken = 0, out_taken = 0, out_seen = 0;
  int        gap_cnt = 0, stall_cnt = 0;
  bit        no_idle = 0;
  bit        stim_done = 0;

  initial forever #1 clk_i = ~clk_i;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic smag_t to_smag(logic [31:0] v);
    smag_t r;
    r.neg = v[31];
    r.mag = v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
    return r;
  endfunction

  function automatic frac_t normalize(logic [31:0] n, logic [31:0] d);
    frac_t f;
    smag_t dd;
    dd = to_smag(d);
    f.num = to_smag(n);
    if (dd.mag == 0) begin
      dd.mag = 1;
      dd.neg = 0;
    end
    if (dd.neg) f.num.neg = !f.num.neg;
    if (f.num.mag == 0) f.num.neg = 0;
    f.den = dd.mag;
    return f;
  endfunction

  function automatic smag_t scale(smag_t a, longint unsigned m, bit mneg);
    smag_t r;
    r.mag = a.mag * m;
    r.neg = (a.neg != mneg) && r.mag != 0;
    return r;
  endfunction

  function automatic smag_t sum(smag_t a, smag_t b);
    smag_t r;
    if (a.neg == b.neg) begin
      r.neg = a.neg;
      r.mag = a.mag + b.mag;
    end else if (a.mag >= b.mag) begin
      r.neg = a.neg;
      r.mag = a.mag - b.mag;
    end else begin
      r.neg = b.neg;
      r.mag = b.mag - a.mag;
    end
    if (r.mag == 0) r.neg = 0;
    return r;
  endfunction

  function automatic frac_t lowest_terms(frac_t f);
    longint unsigned x, y, t;
    if (f.num.mag == 0) begin
      f.num.neg = 0;
      f.den = 1;
      return f;
    end
    x = f.num.mag;
    y = f.den;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    f.num.mag /= x;
    f.den /= x;
    return f;
  endfunction

  function automatic frac_res_t compute_fraction(op_item_t it);
    frac_res_t e;
    frac_t a, b, r;
    smag_t x, y;
    longint unsigned limit, tc;
    bit fits;
    limit = 64'd1 << 31;
    a = normalize(it.a_num, it.a_den);
    b = normalize(it.b_num, it.b_den);
    e = '{num: 0, den: 1, less: 0, equal: 0, div_zero: 0, overflow: 0};
    r.num = '{neg: 0, mag: 0};
    r.den = 1;
    case (it.mode)
      OP_ADD, OP_SUB: begin
        if (it.mode == OP_SUB && b.num.mag != 0) b.num.neg = !b.num.neg;
        r.num = sum(scale(a.num, b.den, 0), scale(b.num, a.den, 0));
        r.den = a.den * b.den;
        r = lowest_terms(r);
      end
      OP_MUL: begin
        r.num = scale(a.num, b.num.mag, b.num.neg);
        r.den = a.den * b.den;
        r = lowest_terms(r);
      end
      OP_DIV: begin
        if (b.num.mag == 0) begin
          r = a;
          e.div_zero = 1;
        end else begin
          r.num = scale(a.num, b.den, b.num.neg);
          r.den = a.den * b.num.mag;
          r = lowest_terms(r);
        end
      end
      OP_NEG: begin
        r = a;
        if (r.num.mag != 0) r.num.neg = !r.num.neg;
        r = lowest_terms(r);
      end
      OP_CMP: begin
        x = scale(a.num, b.den, 0);
        y = scale(b.num, a.den, 0);
        if (x.neg != y.neg) e.less = x.neg;
        else if (x.mag == y.mag) e.equal = 1;
        else e.less = x.neg ? (x.mag > y.mag) : (x.mag < y.mag);
        return e;
      end
      OP_INT: begin
        r.num.mag = a.num.mag / a.den;
        r.num.neg = a.num.neg && r.num.mag != 0;
        r.den = 1;
      end
      default: r = lowest_terms(a);
    endcase
    fits = (r.num.neg ? r.num.mag <= limit : r.num.mag < limit) && r.den < limit;
    tc = r.num.neg ? (64'd0 - r.num.mag) : r.num.mag;
    e.num = tc[31:0];
    e.den = r.den[30:0];
    e.overflow = !fits;
    return e;
  endfunction

  // input side: prediction on accepted transfer; output side: compare
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      op_item_t it;
      it = '{mode: mode_i, a_num: a_num_i, a_den: a_den_i, b_num: b_num_i,
             b_den: b_den_i, drain: 0};
      expected_res.push_back(compute_fraction(it));
      in_taken++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      out_taken++;
      if (expected_res.size() == 0) begin
        report("result transfer with nothing expected");
      end else begin
        frac_res_t e;
        e = expected_res.pop_front();
        if (res_num_o !== e.num)
          report($sformatf("res_num %h, want %h", res_num_o, e.num));
        if (res_den_o !== e.den)
          report($sformatf("res_den %h, want %h", res_den_o, e.den));
        if (less_o !== e.less) report($sformatf("less %b, want %b", less_o, e.less));
        if (equal_o !== e.equal) report($sformatf("equal %b, want %b", equal_o, e.equal));
        if (div_zero_o !== e.div_zero)
          report($sformatf("div_zero %b, want %b", div_zero_o, e.div_zero));
        if (overflow_o !== e.overflow)
          report($sformatf("overflow %b, want %b", overflow_o, e.overflow));
      end
    end
  end

  function automatic int draw_idle();
    if (no_idle) return 0;
    return $urandom_range(10);
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 0;
    end else if (in_valid_i && in_taken < issued) begin
      // hold the stalled payload
    end else if (gap_cnt > 0) begin
      in_valid_i <= 0;
      gap_cnt <= gap_cnt - 1;
    end else if (pending_ops.size() == 0) begin
      in_valid_i <= 0;
    end else if (pending_ops[0].drain && (expected_res.size() != 0 || out_valid_o)) begin
      in_valid_i <= 0;
    end else begin
      op_item_t it;
      it = pending_ops.pop_front();
      mode_i  <= it.mode;
      a_num_i <= it.a_num;
      a_den_i <= it.a_den;
      b_num_i <= it.b_num;
      b_den_i <= it.b_den;
      in_valid_i <= 1;
      issued++;
      gap_cnt <= draw_idle();
      if (issued % 150 == 0) no_idle <= !no_idle;
    end
  end

  // result stall
  always @(negedge clk_i) begin
    if (out_seen != out_taken) begin
      out_seen = out_taken;
      stall_cnt = draw_idle();
    end
    if (stall_cnt > 0) begin
      out_stall_i <= 1;
      stall_cnt--;
    end else begin
      out_stall_i <= 0;
    end
  end

  function automatic logic [31:0] pick_value();
    logic [31:0] corner[6] = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 0, 1, 2};
    case ($urandom_range(9))
      0, 1:    return corner[$urandom_range(5)];
      2, 3, 4: return $urandom_range(200) - 100;
      5, 6:    return $urandom_range(100000) - 50000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(logic [2:0] m, logic [31:0] an, logic [31:0] ad,
                          logic [31:0] bn, logic [31:0] bd, bit dr = 0);
    pending_ops.push_back('{mode: m, a_num: an, a_den: ad, b_num: bn, b_den: bd, drain: dr});
  endtask

  initial begin
    logic [2:0] m;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;

    queue_op(OP_ADD, 1, 2, 1, 3);
    queue_op(OP_SUB, 1, 2, 1, 2);
    queue_op(OP_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
    queue_op(OP_DIV, 3, 4, 0, 5);
    queue_op(OP_DIV, 3, 32'h8000_0000, -2, 7);
    queue_op(OP_NEG, 32'h8000_0000, 1, 0, 0);
    queue_op(OP_NEG, 6, -4, 0, 0);
    queue_op(OP_CMP, 1, 3, 2, 6);
    queue_op(OP_CMP, -1, 3, 1, -3);
    queue_op(OP_CMP, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    queue_op(OP_INT, 32'h8000_0000, -1, 0, 0);
    queue_op(OP_INT, -7, 2, 0, 0);
    queue_op(OP_INT, 5, 0, 0, 0);
    queue_op(OP_RED, 0, -9, 0, 0);
    queue_op(OP_RED, 32'h7fff_ffff, 32'h8000_0000, 0, 0);
    queue_op(OP_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1, 1);
    queue_op(OP_SUB, 32'h8000_0000, 3, 32'h7fff_ffff, 32'h7fff_fffe);
    queue_op(OP_MUL, 32'hffff_ffff, 32'hffff_ffff, 0, 32'h8000_0000);
    queue_op(OP_RED, 12, 0, 0, 0);
    queue_op(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);

    for (int i = 0; i < 1750; i++) begin
      m = $urandom_range(7);
      queue_op(m, pick_value(), pick_value(), pick_value(), pick_value(),
               (i % 500) == 250);
    end

    wait (pending_ops.size() == 0 && in_taken == issued);
    wait (expected_res.size() == 0);
    repeat (300) @(posedge clk_i);
    if (errors == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench: errors");
    $finish;
  end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/rau_pkg.sv
hw/rtl/rau_datapath.sv
hw/rtl/rau_ctrl.sv
hw/rtl/rational_arithmetic_unit.sv
tb/sv/testbench.sv
